[rtl/qvr_pkg.sv]
package qvr_pkg;

  // input and result component width, signed fixed point
  localparam int DW   = 32;
  // 32x32 products
  localparam int PW   = 64;
  // sums and differences of products: norm, dot, cross terms
  localparam int SW   = 66;
  // twice the dot product
  localparam int TWOW = 67;
  // twice the scalar part
  localparam int WW   = 33;
  // low slice of a wide operand in the split multiply
  localparam int SPL  = 33;
  // partial product width
  localparam int PPW  = 67;
  // rotated numerator width
  localparam int TW   = 104;
  // rounding dividend 2|n| + den
  localparam int NW   = TW + 1;
  // divisor 2*den
  localparam int DNW  = SW;
  // quotient bits kept before clamping
  localparam int QW   = DW;
  // divider depth: range check plus one stage per quotient bit
  localparam int DL   = QW + 1;

  localparam logic signed [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

endpackage

[rtl/qvr_div.sv]
module qvr_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qvr_pkg::NW-1:0]     num,
  input  logic [qvr_pkg::DNW-1:0]    den2,
  output logic [qvr_pkg::QW-1:0]     quo,
  output logic                       ovf
);

  localparam int NW  = qvr_pkg::NW;
  localparam int DNW = qvr_pkg::DNW;
  localparam int QW  = qvr_pkg::QW;

  logic [NW-1:0]  rem_r [0:QW-1];
  logic [DNW-1:0] den_r [0:QW-1];
  logic [QW-1:0]  q_r   [0:QW];
  logic           ovf_r [0:QW];

  // quotient of 2^QW or more never fits: flag it up front
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den2;
      q_r[0]   <= '0;
      ovf_r[0] <= (num >= ({{(NW-DNW){1'b0}}, den2} << QW));
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [NW-1:0] dsh;
    logic [NW:0]   diff;

    assign dsh  = {{(NW-DNW){1'b0}}, den_r[k-1]} << (QW - k);
    assign diff = {1'b0, rem_r[k-1]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[k] <= ovf_r[k-1];
        if (!diff[NW]) begin
          q_r[k] <= q_r[k-1] | ({{(QW-1){1'b0}}, 1'b1} << (QW - k));
        end else begin
          q_r[k] <= q_r[k-1];
        end
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_r[k-1];
          if (!diff[NW]) begin
            rem_r[k] <= diff[NW-1:0];
          end else begin
            rem_r[k] <= rem_r[k-1];
          end
        end
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

[rtl/quaternion_vector_rotate_top.sv]
// Rotates a vector by a quaternion, both signed Q16.16. The quaternion need not
// be unit length: the result is ((w^2-|u|^2)v + 2(u.v)u + 2w(u x v)) / |q|^2,
// rounded to nearest with ties away from zero, clamped to the 32-bit range with
// out_saturated set. An all-zero quaternion passes the vector through and sets
// out_degenerate. One item is accepted every cycle while in_stall is low; each
// result passes through the arithmetic stages, then the bit-per-stage divider that
// forms the rounded quotient. A stall on the result side freezes the whole pipe.
module quaternion_vector_rotate_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [qvr_pkg::DW-1:0]     in_quat_x,
  input  logic signed [qvr_pkg::DW-1:0]     in_quat_y,
  input  logic signed [qvr_pkg::DW-1:0]     in_quat_z,
  input  logic signed [qvr_pkg::DW-1:0]     in_quat_w,
  input  logic signed [qvr_pkg::DW-1:0]     in_vec_x,
  input  logic signed [qvr_pkg::DW-1:0]     in_vec_y,
  input  logic signed [qvr_pkg::DW-1:0]     in_vec_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qvr_pkg::DW-1:0]     out_rot_x,
  output logic signed [qvr_pkg::DW-1:0]     out_rot_y,
  output logic signed [qvr_pkg::DW-1:0]     out_rot_z,
  output logic                              out_saturated,
  output logic                              out_degenerate
);

  localparam int DW   = qvr_pkg::DW;
  localparam int PW   = qvr_pkg::PW;
  localparam int SW   = qvr_pkg::SW;
  localparam int TWOW = qvr_pkg::TWOW;
  localparam int WW   = qvr_pkg::WW;
  localparam int SPL  = qvr_pkg::SPL;
  localparam int PPW  = qvr_pkg::PPW;
  localparam int TW   = qvr_pkg::TW;
  localparam int NW   = qvr_pkg::NW;
  localparam int DNW  = qvr_pkg::DNW;
  localparam int QW   = qvr_pkg::QW;
  localparam int DL   = qvr_pkg::DL;

  typedef struct packed {
    logic [2:0]      neg;
    logic            degen;
    logic [3*DW-1:0] vec;
  } side_t;

  function automatic logic signed [PPW-1:0] mul_lo(input logic signed [TWOW-1:0] big,
                                                   input logic signed [WW-1:0] sml);
    logic signed [SPL:0]   lo;
    logic signed [PPW-1:0] r;
    lo = {1'b0, big[SPL-1:0]};
    r  = lo * sml;
    return r;
  endfunction

  function automatic logic signed [PPW-1:0] mul_hi(input logic signed [TWOW-1:0] big,
                                                   input logic signed [WW-1:0] sml);
    logic signed [TWOW-SPL-1:0] hi;
    logic signed [PPW-1:0]      r;
    hi = big[TWOW-1:SPL];
    r  = hi * sml;
    return r;
  endfunction

  logic en;
  logic out_valid_r;
  logic [5:0] vld_r;
  logic [DL-1:0] dvld_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = out_valid_r && out_stall;

  logic signed [DW-1:0] qin [3];
  logic signed [DW-1:0] vin [3];

  assign qin[0] = in_quat_x;
  assign qin[1] = in_quat_y;
  assign qin[2] = in_quat_z;
  assign vin[0] = in_vec_x;
  assign vin[1] = in_vec_y;
  assign vin[2] = in_vec_z;

  // stage 1: all 32x32 products
  logic signed [PW-1:0] sq1_r [3];
  logic signed [PW-1:0] dt1_r [3];
  logic signed [PW-1:0] cp1_r [3];
  logic signed [PW-1:0] cm1_r [3];
  logic signed [PW-1:0] ww1_r;
  logic signed [DW-1:0] q1_r  [3];
  logic signed [DW-1:0] v1_r  [3];
  logic signed [DW-1:0] w1_r;

  for (genvar i = 0; i < 3; i++) begin : g_s1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        sq1_r[i] <= qin[i] * qin[i];
        dt1_r[i] <= qin[i] * vin[i];
        cp1_r[i] <= qin[J] * vin[K];
        cm1_r[i] <= qin[K] * vin[J];
        q1_r[i]  <= qin[i];
        v1_r[i]  <= vin[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww1_r <= in_quat_w * in_quat_w;
      w1_r  <= in_quat_w;
    end
  end

  // stage 2: norm, scalar weight, dot and cross
  logic signed [SW-1:0]   uu_c, wwx_c, den_c, dot_c;
  logic signed [SW-1:0]   s2_r, den2_r;
  logic signed [TWOW-1:0] d2_r;
  logic signed [WW-1:0]   w2_r;
  logic                   dg2_r;
  logic signed [SW-1:0]   cr2_r [3];
  logic signed [DW-1:0]   q2_r  [3];
  logic signed [DW-1:0]   v2_r  [3];

  always_comb begin
    uu_c  = SW'(sq1_r[0]) + SW'(sq1_r[1]) + SW'(sq1_r[2]);
    wwx_c = SW'(ww1_r);
    den_c = uu_c + wwx_c;
    dot_c = SW'(dt1_r[0]) + SW'(dt1_r[1]) + SW'(dt1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= wwx_c - uu_c;
      d2_r   <= {dot_c, 1'b0};
      w2_r   <= {w1_r, 1'b0};
      den2_r <= den_c;
      dg2_r  <= (den_c == '0);
      for (int i = 0; i < 3; i++) begin
        cr2_r[i] <= SW'(cp1_r[i]) - SW'(cm1_r[i]);
        q2_r[i]  <= q1_r[i];
        v2_r[i]  <= v1_r[i];
      end
    end
  end

  // stage 3: wide products split into two halves each
  logic signed [PPW-1:0] ppl3_r [3][3];
  logic signed [PPW-1:0] pph3_r [3][3];
  logic signed [SW-1:0]  den3_r;
  logic                  dg3_r;
  logic signed [DW-1:0]  v3_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ppl3_r[i][0] <= mul_lo({s2_r[SW-1], s2_r}, {v2_r[i][DW-1], v2_r[i]});
        pph3_r[i][0] <= mul_hi({s2_r[SW-1], s2_r}, {v2_r[i][DW-1], v2_r[i]});
        ppl3_r[i][1] <= mul_lo(d2_r, {q2_r[i][DW-1], q2_r[i]});
        pph3_r[i][1] <= mul_hi(d2_r, {q2_r[i][DW-1], q2_r[i]});
        ppl3_r[i][2] <= mul_lo({cr2_r[i][SW-1], cr2_r[i]}, w2_r);
        pph3_r[i][2] <= mul_hi({cr2_r[i][SW-1], cr2_r[i]}, w2_r);
        v3_r[i]      <= v2_r[i];
      end
      den3_r <= den2_r;
      dg3_r  <= dg2_r;
    end
  end

  // stage 4: recombine halves
  logic signed [TW-1:0] tm4_r [3][3];
  logic signed [SW-1:0] den4_r;
  logic                 dg4_r;
  logic signed [DW-1:0] v4_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 3; t++) begin
          tm4_r[i][t] <= (TW'(pph3_r[i][t]) <<< SPL) + TW'(ppl3_r[i][t]);
        end
        v4_r[i] <= v3_r[i];
      end
      den4_r <= den3_r;
      dg4_r  <= dg3_r;
    end
  end

  // stage 5: numerators
  logic signed [TW-1:0] n5_r [3];
  logic signed [SW-1:0] den5_r;
  logic                 dg5_r;
  logic signed [DW-1:0] v5_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n5_r[i] <= tm4_r[i][0] + tm4_r[i][1] + tm4_r[i][2];
        v5_r[i] <= v4_r[i];
      end
      den5_r <= den4_r;
      dg5_r  <= dg4_r;
    end
  end

  // stage 6: dividend 2|n| + den, divisor 2*den
  logic [NW-1:0]        num6_r [3];
  logic [2:0]           neg6_r;
  logic [DNW-1:0]       dd6_r;
  logic                 dg6_r;
  logic signed [DW-1:0] v6_r [3];
  logic [NW-1:0]        denx_c;

  assign denx_c = {{(NW-SW){1'b0}}, den5_r};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg6_r[i] <= n5_r[i][TW-1];
        if (n5_r[i][TW-1]) begin
          num6_r[i] <= denx_c - {n5_r[i], 1'b0};
        end else begin
          num6_r[i] <= denx_c + {n5_r[i], 1'b0};
        end
        v6_r[i] <= v5_r[i];
      end
      dd6_r <= {den5_r[SW-2:0], 1'b0};
      dg6_r <= dg5_r;
    end
  end

  logic [QW-1:0] quo [3];
  logic [2:0]    ovf;

  for (genvar i = 0; i < 3; i++) begin : g_div
    qvr_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num6_r[i]),
      .den2 (dd6_r),
      .quo  (quo[i]),
      .ovf  (ovf[i])
    );
  end

  // side data rides alongside the divider
  side_t sd_r [0:DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= '{neg: neg6_r, degen: dg6_r, vec: {v6_r[2], v6_r[1], v6_r[0]}};
      for (int k = 1; k < DL; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // final: sign, clamp, pass-through
  logic signed [DW-1:0] rot_c [3];
  logic [2:0]           sat_c;
  logic signed [DW-1:0] rot_r [3];
  logic                 sat_r;
  logic                 dgo_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd_r[DL-1].neg[i]) begin
        sat_c[i] = ovf[i] || (quo[i][QW-1] && (quo[i][QW-2:0] != '0));
      end else begin
        sat_c[i] = ovf[i] || quo[i][QW-1];
      end
      if (sd_r[DL-1].degen) begin
        sat_c[i] = 1'b0;
        rot_c[i] = sd_r[DL-1].vec[i*DW +: DW];
      end else if (sat_c[i]) begin
        rot_c[i] = sd_r[DL-1].neg[i] ? qvr_pkg::SAT_NEG : qvr_pkg::SAT_POS;
      end else if (sd_r[DL-1].neg[i]) begin
        rot_c[i] = -quo[i];
      end else begin
        rot_c[i] = quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rot_r[i] <= rot_c[i];
      end
      sat_r <= |sat_c;
      dgo_r <= sd_r[DL-1].degen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[4:0], in_valid};
      dvld_r      <= {dvld_r[DL-2:0], vld_r[5]};
      out_valid_r <= dvld_r[DL-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rot_x      = rot_r[0];
  assign out_rot_y      = rot_r[1];
  assign out_rot_z      = rot_r[2];
  assign out_saturated  = sat_r;
  assign out_degenerate = dgo_r;

  a_sat_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_saturated && out_degenerate))
    else $error("saturated and degenerate both set");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_rot_x == qvr_pkg::SAT_POS || out_rot_x == qvr_pkg::SAT_NEG ||
       out_rot_y == qvr_pkg::SAT_POS || out_rot_y == qvr_pkg::SAT_NEG ||
       out_rot_z == qvr_pkg::SAT_POS || out_rot_z == qvr_pkg::SAT_NEG))
    else $error("saturated flag without a clamped component");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dvld_r) && $stable(vld_r))
    else $error("pipeline advanced while stalled");

endmodule
